[hw/rtl/stage_range_interval_merge_assert.svh]
// ----------------------------------------------------------------------------
// stage range interval merge assertion macros
// shared checks written against the clk / rst of the including module
// ----------------------------------------------------------------------------
`ifndef STAGE_RANGE_INTERVAL_MERGE_ASSERT_SVH
`define STAGE_RANGE_INTERVAL_MERGE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SRIM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srim: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SRIM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srim: next-cycle check failed");

`endif

[hw/rtl/srim_pkg.sv]
// ----------------------------------------------------------------------------
// srim_pkg
// widths, list entry type, controller states and command / status groups
// ----------------------------------------------------------------------------
`default_nettype none

package srim_pkg;

  localparam int NUM_STAGES  = 32;
  localparam int OFFSET_BITS = 16;
  localparam int END_BITS    = OFFSET_BITS + 1;
  localparam int MASK_BITS   = 32;
  localparam int STAGE_W     = $clog2(NUM_STAGES);
  localparam int CNT_W       = $clog2(NUM_STAGES + 1);

  // one interval: stage mask, start, exclusive end
  typedef struct packed {
    logic [MASK_BITS-1:0]   mask;
    logic [OFFSET_BITS-1:0] lo;
    logic [END_BITS-1:0]    hi;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_P1,
    S_P2,
    S_OUT_PREP,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_next;
    logic p1_start;
    logic p1_step;
    logic p2_start;
    logic p2_step;
    logic out_prep;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cur_used;
    logic stage_last;
    logic rd_done;
    logic out_free;
    logic emit_last;
    logic cnt_zero;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/srim_in_if.sv]
// ----------------------------------------------------------------------------
// srim_in_if
// range channel: one byte range with its stage mask per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface srim_in_if
  import srim_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [MASK_BITS-1:0]   stage_mask;
  logic [OFFSET_BITS-1:0] range_offset;
  logic [OFFSET_BITS-1:0] range_size;
  logic                   batch_last;

  modport source (
    output valid, stage_mask, range_offset, range_size, batch_last,
    input  ready
  );

  modport sink (
    input  valid, stage_mask, range_offset, range_size, batch_last,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/srim_out_if.sv]
// ----------------------------------------------------------------------------
// srim_out_if
// merged interval channel: one merged interval per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface srim_out_if
  import srim_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [MASK_BITS-1:0]   merged_mask;
  logic [OFFSET_BITS-1:0] merged_offset;
  logic [END_BITS-1:0]    merged_size;
  logic                   result_valid;
  logic                   result_last;

  modport source (
    output valid, merged_mask, merged_offset, merged_size, result_valid, result_last,
    input  ready
  );

  modport sink (
    input  valid, merged_mask, merged_offset, merged_size, result_valid, result_last,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/srim_ctrl.sv]
// ----------------------------------------------------------------------------
// srim_ctrl
// sequencer: load, per-stage two-pass merge over the list, result drain
// ----------------------------------------------------------------------------
`default_nettype none

module srim_ctrl
  import srim_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_last,
  output logic             in_ready,
  input  wire sts_t        sts,
  output cmd_t             cmd,
  output ctrl_state_t      state
);

  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_last) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.cur_used) state_next = S_P1;
        else if (sts.stage_last) state_next = S_OUT_PREP;
      end
      S_P1: begin
        if (sts.rd_done) state_next = S_P2;
      end
      S_P2: begin
        if (sts.rd_done) state_next = sts.stage_last ? S_OUT_PREP : S_SCAN;
      end
      S_OUT_PREP: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free && sts.emit_last) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.load       = in_valid;
        cmd.scan_start = in_valid && in_last;
      end
      S_SCAN: begin
        if (sts.cur_used) cmd.p1_start = 1'b1;
        else cmd.scan_next = 1'b1;
      end
      S_P1: begin
        if (sts.rd_done) cmd.p2_start = 1'b1;
        else cmd.p1_step = 1'b1;
      end
      S_P2: begin
        cmd.p2_step   = 1'b1;
        cmd.scan_next = sts.rd_done;
      end
      S_OUT_PREP: begin
        cmd.out_prep = 1'b1;
      end
      S_EMIT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/srim_dpath.sv]
// ----------------------------------------------------------------------------
// srim_dpath
// per-stage hull store, ping-pong merged list, walk counters, output register
// ----------------------------------------------------------------------------
`default_nettype none

module srim_dpath
  import srim_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  input  wire logic [MASK_BITS-1:0]   stage_mask,
  input  wire logic [OFFSET_BITS-1:0] range_offset,
  input  wire logic [OFFSET_BITS-1:0] range_size,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic [MASK_BITS-1:0]        out_mask,
  output logic [OFFSET_BITS-1:0]      out_offset,
  output logic [END_BITS-1:0]         out_size,
  output logic                        out_rvalid,
  output logic                        out_last
);

  // per-stage hulls
  logic [NUM_STAGES-1:0]  used;
  logic [OFFSET_BITS-1:0] st_lo [NUM_STAGES];
  logic [END_BITS-1:0]    st_hi [NUM_STAGES];

  // merged list, two banks; bank selects the current source
  entry_t lst0 [NUM_STAGES];
  entry_t lst1 [NUM_STAGES];
  logic   bank;

  logic [STAGE_W-1:0]     sidx;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       ridx;
  logic [CNT_W-1:0]       widx;
  logic                   ins;
  logic [OFFSET_BITS-1:0] ns;
  logic [END_BITS-1:0]    ne;
  logic [MASK_BITS-1:0]   nm;
  logic                   out_full;

  logic [END_BITS-1:0]    range_end;
  logic [OFFSET_BITS-1:0] os;
  logic [END_BITS-1:0]    oe;
  entry_t                 rd_e;
  entry_t                 new_e;
  entry_t                 wr_data;
  logic                   wr_en;
  logic                   adv;
  logic                   ovl;
  logic                   key_gt;
  logic                   rd_done;
  logic                   emit_last;

  assign range_end = END_BITS'(range_offset) + END_BITS'(range_size);
  assign os        = st_lo[sidx];
  assign oe        = st_hi[sidx];
  assign rd_e      = bank ? lst1[ridx[STAGE_W-1:0]] : lst0[ridx[STAGE_W-1:0]];
  assign rd_done   = (ridx == cnt);
  assign emit_last = (cnt == '0) || ((ridx + CNT_W'(1)) == cnt);

  // strict overlap against the stage's own interval
  assign ovl    = (oe > END_BITS'(rd_e.lo)) && (rd_e.hi > END_BITS'(os));
  // list entry orders after the new hull
  assign key_gt = (rd_e.lo > ns) || ((rd_e.lo == ns) && (rd_e.hi > ne));

  always_comb begin
    new_e.mask = nm;
    new_e.lo   = ns;
    new_e.hi   = ne;
  end

  // second pass: drop absorbed entries, insert new hull in order
  always_comb begin
    wr_en   = 1'b0;
    adv     = 1'b0;
    wr_data = new_e;
    if (cmd.p2_step) begin
      priority if (rd_done) begin
        wr_en = !ins;
      end else if (ovl) begin
        adv = 1'b1;
      end else if (!ins && key_gt) begin
        wr_en = 1'b1;
      end else begin
        wr_en   = 1'b1;
        wr_data = rd_e;
        adv     = 1'b1;
      end
    end
  end

  always_comb begin
    sts.cur_used   = used[sidx];
    sts.stage_last = (sidx == STAGE_W'(NUM_STAGES - 1));
    sts.rd_done    = rd_done;
    sts.out_free   = !out_full || out_ready;
    sts.emit_last  = emit_last;
    sts.cnt_zero   = (cnt == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.load) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (stage_mask[s]) used[s] <= 1'b1;
      end
    end else if (cmd.out_prep) begin
      used <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (stage_mask[s]) begin
          if (!used[s] || (range_offset < st_lo[s])) st_lo[s] <= range_offset;
          if (!used[s] || (range_end > st_hi[s])) st_hi[s] <= range_end;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (bank) lst0[widx[STAGE_W-1:0]] <= wr_data;
      else lst1[widx[STAGE_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sidx <= '0;
      cnt  <= '0;
      bank <= 1'b0;
      ridx <= '0;
      widx <= '0;
      ins  <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        sidx <= '0;
        cnt  <= '0;
      end else if (cmd.scan_next) begin
        sidx <= sidx + STAGE_W'(1);
      end

      priority if (cmd.p1_start || cmd.p2_start || cmd.out_prep) begin
        ridx <= '0;
      end else if (cmd.p1_step || adv || cmd.out_load) begin
        ridx <= ridx + CNT_W'(1);
      end

      if (cmd.p2_start) begin
        widx <= '0;
        ins  <= 1'b0;
      end else if (cmd.p2_step) begin
        if (wr_en) widx <= widx + CNT_W'(1);
        if (wr_en && !adv && !rd_done) ins <= 1'b1;
        if (rd_done) begin
          cnt  <= ins ? widx : widx + CNT_W'(1);
          bank <= ~bank;
        end
      end
    end
  end

  // first pass: hull and mask of everything the stage absorbs
  always_ff @(posedge clk) begin
    if (cmd.p1_start) begin
      ns <= os;
      ne <= oe;
      nm <= MASK_BITS'(1) << sidx;
    end else if (cmd.p1_step && ovl) begin
      nm <= nm | rd_e.mask;
      if (rd_e.lo < ns) ns <= rd_e.lo;
      if (rd_e.hi > ne) ne <= rd_e.hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.out_load) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cnt == '0) begin
        out_mask   <= '0;
        out_offset <= '0;
        out_size   <= '0;
        out_rvalid <= 1'b0;
        out_last   <= 1'b1;
      end else begin
        out_mask   <= rd_e.mask;
        out_offset <= rd_e.lo;
        out_size   <= rd_e.hi - END_BITS'(rd_e.lo);
        out_rvalid <= 1'b1;
        out_last   <= emit_last;
      end
    end
  end

  assign out_valid = out_full;

endmodule

`default_nettype wire

[hw/rtl/stage_range_interval_merge.sv]
// ----------------------------------------------------------------------------
// stage_range_interval_merge
// merges per-stage byte ranges into ordered disjoint intervals per batch
// ----------------------------------------------------------------------------
//
// channel  dir  payload                                          role
// -------  ---  -----------------------------------------------  ---------------------
// ranges   in   stage_mask, range_offset, range_size, batch_last one range per transfer
// merged   out  merged_mask, merged_offset, merged_size,         one merged interval
//               result_valid, result_last                        per transfer
//
// a range without batch_last only widens hulls; ready is high whenever the merge is idle
// on batch_last the stages are scanned in order and, per used stage, a hull pass and an
// insert pass walk the list through one read port; then a prep state clears the used bits
// results leave one per cycle while merged.ready holds, at most 32 per batch
// the last result may still sit in the output register while new ranges come in
// synchronous active-high reset clears the used bits, list count and handshake state
//
`default_nettype none

`include "stage_range_interval_merge_assert.svh"

module stage_range_interval_merge
  import srim_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  srim_in_if.sink     ranges,
  srim_out_if.source  merged
);

  cmd_t        cmd;
  sts_t        sts;
  ctrl_state_t state;
  logic        in_ready;

  // sequencer: owns the handshake on the range side and the walk order
  srim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ranges.valid),
    .in_last  (ranges.batch_last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  assign ranges.ready = in_ready;

  // datapath: hull store, merged list banks and the result register
  srim_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .stage_mask   (ranges.stage_mask),
    .range_offset (ranges.range_offset),
    .range_size   (ranges.range_size),
    .out_ready    (merged.ready),
    .out_valid    (merged.valid),
    .out_mask     (merged.merged_mask),
    .out_offset   (merged.merged_offset),
    .out_size     (merged.merged_size),
    .out_rvalid   (merged.result_valid),
    .out_last     (merged.result_last)
  );

  // an empty-batch marker is always the only, hence last, result
  `SRIM_ASSERT_SAME(a_empty_is_last, merged.valid && !merged.result_valid, merged.result_last)
  // a new batch merge starts from an empty list
  `SRIM_ASSERT_NEXT(a_scan_clears_count, cmd.scan_start, sts.cnt_zero)
  // finishing the insert pass returns to the stage scan or to the drain
  `SRIM_ASSERT_NEXT(a_p2_exit, (state == S_P2) && sts.rd_done, (state == S_SCAN) || (state == S_OUT_PREP))

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks stage_range_interval_merge against a behavioral interval merger;
// directed corner batches, then random batches with random gaps on both
// channels, every merged interval compared field by field in order
// ----------------------------------------------------------------------------

module testbench;
  import srim_pkg::*;

  // a slow correct run stays far below this; only a hang gets here
  localparam int CYCLE_LIMIT  = 6000000;
  localparam int RANDOM_RANGES = 350;
  localparam int DRAIN_CYCLES  = 64;

  // one range as it goes into the block
  typedef struct packed {
    logic [MASK_BITS-1:0]   mask;
    logic [OFFSET_BITS-1:0] offset;
    logic [OFFSET_BITS-1:0] size;
    logic                   last;
  } range_item_t;

  // one merged interval as it should come out of the block
  typedef struct packed {
    logic [MASK_BITS-1:0]   mask;
    logic [OFFSET_BITS-1:0] offset;
    logic [END_BITS-1:0]    size;
    logic                   ok;
    logic                   last;
  } merged_result_t;

  logic clk;
  logic rst;

  srim_in_if  ranges_ch ();
  srim_out_if merged_ch ();

  stage_range_interval_merge u_top (
    .clk    (clk),
    .rst    (rst),
    .ranges (ranges_ch),
    .merged (merged_ch)
  );

  // clock: 12 ns period
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ranges waiting to be driven, merged intervals waiting to be seen
  range_item_t    pending_ranges[$];
  merged_result_t expected_intervals[$];

  // per-stage hull of the current batch
  logic                   stage_used [NUM_STAGES];
  logic [OFFSET_BITS-1:0] stage_lo   [NUM_STAGES];
  logic [END_BITS-1:0]    stage_hi   [NUM_STAGES];

  // run statistics
  int mismatches;
  int ranges_accepted;
  int batches_done;
  int empty_batches;
  int intervals_checked;
  int widest_batch;
  int cycle_count;

  // handshake bookkeeping for the driver side
  logic        range_taken;
  range_item_t next_range;
  int          send_gap;
  int          recv_stall;
  bit          send_calm;
  bit          recv_calm;

  // --------------------------------------------------------------------------
  // mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at interval %0d: %s got 0x%0h, expected 0x%0h",
             intervals_checked, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // behavioral merger
  // --------------------------------------------------------------------------

  // merge the used stages in ascending order into a sorted disjoint list,
  // queue the resulting intervals, then clear the batch
  task automatic merge_batch();
    entry_t         merged_list[$];
    entry_t         kept[$];
    entry_t         cur;
    int             pos;
    merged_result_t r;
    merged_list = {};
    for (int s = 0; s < NUM_STAGES; s++) begin
      if (stage_used[s]) begin
        cur      = '0;
        cur.mask = '0;
        cur.mask[s] = 1'b1;
        cur.lo   = stage_lo[s];
        cur.hi   = stage_hi[s];
        kept     = {};
        // overlap is tested against the stage's own interval, strict on both ends
        foreach (merged_list[i]) begin
          if (stage_hi[s] > {1'b0, merged_list[i].lo} &&
              merged_list[i].hi > {1'b0, stage_lo[s]}) begin
            cur.mask |= merged_list[i].mask;
            if (merged_list[i].lo < cur.lo) cur.lo = merged_list[i].lo;
            if (merged_list[i].hi > cur.hi) cur.hi = merged_list[i].hi;
          end else begin
            kept.push_back(merged_list[i]);
          end
        end
        // sorted by start then end; equal keys keep the earlier stage first
        pos = 0;
        while (pos < kept.size() && (kept[pos].lo < cur.lo ||
               (kept[pos].lo == cur.lo && kept[pos].hi <= cur.hi)))
          pos++;
        merged_list = {};
        foreach (kept[i]) begin
          if (i == pos) merged_list.push_back(cur);
          merged_list.push_back(kept[i]);
        end
        if (pos == kept.size()) merged_list.push_back(cur);
      end
    end

    if (merged_list.size() == 0) begin
      // no stage bit in the whole batch: a single empty marker
      r      = '0;
      r.last = 1'b1;
      expected_intervals.push_back(r);
      empty_batches++;
    end else begin
      foreach (merged_list[i]) begin
        r.mask   = merged_list[i].mask;
        r.offset = merged_list[i].lo;
        r.size   = merged_list[i].hi - {1'b0, merged_list[i].lo};
        r.ok     = 1'b1;
        r.last   = (i == merged_list.size() - 1);
        expected_intervals.push_back(r);
      end
      if (merged_list.size() > widest_batch) widest_batch = merged_list.size();
    end
    batches_done++;
    foreach (stage_used[s]) stage_used[s] = 1'b0;
  endtask

  // widen every selected stage to the hull; ends are 17 bits so they never wrap
  task automatic absorb_range(range_item_t it);
    logic [END_BITS-1:0] hi;
    hi = {1'b0, it.offset} + {1'b0, it.size};
    for (int s = 0; s < NUM_STAGES; s++) begin
      if (it.mask[s]) begin
        if (!stage_used[s]) begin
          stage_used[s] = 1'b1;
          stage_lo[s]   = it.offset;
          stage_hi[s]   = hi;
        end else begin
          if (it.offset < stage_lo[s]) stage_lo[s] = it.offset;
          if (hi > stage_hi[s]) stage_hi[s] = hi;
        end
      end
    end
    ranges_accepted++;
    if (it.last) merge_batch();
  endtask

  // compare one merged transfer with the oldest expectation
  task automatic check_interval();
    merged_result_t want;
    if (expected_intervals.size() == 0) begin
      report_mismatch("unexpected transfer, merged_mask", merged_ch.merged_mask, '0);
    end else begin
      want = expected_intervals.pop_front();
      if (merged_ch.merged_mask !== want.mask)
        report_mismatch("merged_mask", merged_ch.merged_mask, want.mask);
      if (merged_ch.merged_offset !== want.offset)
        report_mismatch("merged_offset", merged_ch.merged_offset, want.offset);
      if (merged_ch.merged_size !== want.size)
        report_mismatch("merged_size", merged_ch.merged_size, want.size);
      if (merged_ch.result_valid !== want.ok)
        report_mismatch("result_valid", merged_ch.result_valid, want.ok);
      if (merged_ch.result_last !== want.last)
        report_mismatch("result_last", merged_ch.result_last, want.last);
    end
    intervals_checked++;
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_range(logic [MASK_BITS-1:0] mask, int offset, int size, bit last);
    range_item_t it;
    it.mask   = mask;
    it.offset = offset[OFFSET_BITS-1:0];
    it.size   = size[OFFSET_BITS-1:0];
    it.last   = last;
    pending_ranges.push_back(it);
  endtask

  // a mask with a handful of random stage bits
  function automatic logic [MASK_BITS-1:0] few_stages(int count);
    logic [MASK_BITS-1:0] m;
    m = '0;
    repeat (count) m[$urandom_range(0, MASK_BITS - 1)] = 1'b1;
    return m;
  endfunction

  // styles: crowded low region (lots of overlap), full field range,
  // point ranges near zero (touching and empty cases), and noisy mixes
  function automatic range_item_t random_range(int style);
    range_item_t it;
    it.last = 1'b0;
    case (style)
      0, 1, 2, 3, 4, 5: begin
        it.mask   = few_stages($urandom_range(1, 3));
        it.offset = OFFSET_BITS'($urandom_range(0, 255));
        it.size   = OFFSET_BITS'($urandom_range(0, 40));
      end
      6, 7: begin
        it.mask   = $urandom_range(0, 1) ? $urandom : few_stages($urandom_range(1, 4));
        it.offset = OFFSET_BITS'($urandom_range(0, 65535));
        it.size   = OFFSET_BITS'($urandom_range(0, 65535));
      end
      8: begin
        it.mask   = few_stages($urandom_range(1, 2));
        it.offset = OFFSET_BITS'($urandom_range(0, 31));
        it.size   = ($urandom_range(0, 2) == 0) ? '0 : OFFSET_BITS'($urandom_range(0, 4));
      end
      default: begin
        it.mask   = ($urandom_range(0, 3) == 0) ? '0 : few_stages($urandom_range(1, 6));
        it.offset = OFFSET_BITS'($urandom_range(0, 4095));
        it.size   = OFFSET_BITS'($urandom_range(0, 600));
      end
    endcase
    return it;
  endfunction

  // idle length: mostly none or short, now and then long; calm means none
  function automatic int pick_idle(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // range driver: changes on the falling edge, one item per transfer
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      ranges_ch.valid <= 1'b0;
    end else if (!ranges_ch.valid || range_taken) begin
      if (send_gap > 0) begin
        ranges_ch.valid <= 1'b0;
        send_gap--;
      end else if (pending_ranges.size() > 0) begin
        next_range = pending_ranges.pop_front();
        ranges_ch.valid        <= 1'b1;
        ranges_ch.stage_mask   <= next_range.mask;
        ranges_ch.range_offset <= next_range.offset;
        ranges_ch.range_size   <= next_range.size;
        ranges_ch.batch_last   <= next_range.last;
        send_gap = pick_idle(send_calm);
        // switch between gappy and back-to-back stretches
        if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
      end else begin
        ranges_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // merged receiver: random stalls, with calm stretches of steady ready
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      merged_ch.ready <= 1'b0;
    end else if (recv_stall > 0) begin
      merged_ch.ready <= 1'b0;
      recv_stall--;
    end else begin
      merged_ch.ready <= 1'b1;
      recv_stall = pick_idle(recv_calm);
      if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: samples both channels on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      range_taken <= 1'b0;
      foreach (stage_used[s]) stage_used[s] = 1'b0;
    end else begin
      range_taken <= ranges_ch.valid && ranges_ch.ready;
      // results of an older batch sit ahead of anything this transfer adds
      if (merged_ch.valid && merged_ch.ready) check_interval();
      if (ranges_ch.valid && ranges_ch.ready)
        absorb_range({ranges_ch.stage_mask, ranges_ch.range_offset,
                      ranges_ch.range_size, ranges_ch.batch_last});
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d intervals still expected",
               cycle_count, expected_intervals.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    range_item_t it;
    int          style;
    int          batch_len;
    int          random_count;

    rst                    = 1'b1;
    ranges_ch.valid        = 1'b0;
    ranges_ch.stage_mask   = '0;
    ranges_ch.range_offset = '0;
    ranges_ch.range_size   = '0;
    ranges_ch.batch_last   = 1'b0;
    merged_ch.ready        = 1'b0;
    range_taken            = 1'b0;
    send_gap               = 0;
    recv_stall             = 0;
    send_calm              = 1'b0;
    recv_calm              = 1'b0;
    mismatches             = 0;
    ranges_accepted        = 0;
    batches_done           = 0;
    empty_batches          = 0;
    intervals_checked      = 0;
    widest_batch           = 0;
    cycle_count            = 0;

    // batch with no stage bit: a single empty marker
    add_range(32'h0000_0000, 16'h1234, 5, 1);
    // all stages on the largest range: one interval, widest size
    add_range(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1);
    // touching intervals stay apart, an empty range at the seam too
    add_range(32'h0000_0001, 0, 16, 0);
    add_range(32'h0000_0002, 16, 16, 0);
    add_range(32'h0000_0004, 32, 0, 1);
    // empty range strictly inside is merged; widening by two points
    add_range(32'h0000_0008, 100, 50, 0);
    add_range(32'h0000_0010, 120, 0, 0);
    add_range(32'h0000_0020, 60, 0, 0);
    add_range(32'h0000_0020, 200, 0, 1);
    // equal keys keep stage order; same start ordered by end
    add_range(32'h0000_0300, 5, 0, 0);
    add_range(32'h0000_2000, 5, 4, 0);
    add_range(32'h0000_4000, 0, 5, 1);
    // top stage bit and a point on the exclusive end of a big range
    add_range(32'h8000_0001, 0, 16'hFFFF, 0);
    add_range(32'h4000_0000, 16'hFFFF, 0, 1);
    // one stage bridging two, then a container, a stage widened twice
    add_range(32'h0000_0001, 10, 10, 0);
    add_range(32'h0000_0002, 30, 10, 0);
    add_range(32'h0000_0004, 15, 20, 0);
    add_range(32'h0000_0008, 0, 100, 0);
    add_range(32'h0000_0002, 50, 10, 0);
    add_range(32'h0000_0010, 200, 10, 1);
    // ranges followed by a last item that carries no stage bits
    add_range(32'h0010_0000, 1000, 10, 0);
    add_range(32'h0000_0000, 0, 0, 1);
    // alternating mask bits, half-range offset and size
    add_range(32'hAAAA_5555, 16'h8000, 16'h8000, 1);

    // random batches, mostly short, some long enough to fill many stages
    random_count = 0;
    while (random_count < RANDOM_RANGES) begin
      style     = $urandom_range(0, 9);
      batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
      for (int k = 0; k < batch_len; k++) begin
        it      = random_range(style);
        it.last = (k == batch_len - 1);
        if (it.last && $urandom_range(0, 19) == 0) it.mask = '0;
        pending_ranges.push_back(it);
        // mask-free ranges inside a batch do nothing, so they are not counted
        if (it.mask != '0 || it.last) random_count++;
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all ranges sent and every merged interval seen
    while (pending_ranges.size() != 0 || ranges_ch.valid || expected_intervals.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d range transfers in %0d batches, %0d of them empty",
             ranges_accepted, batches_done, empty_batches);
    $display("compared %0d merged intervals, up to %0d in one batch, %0d mismatches",
             intervals_checked, widest_batch, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/srim_pkg.sv
hw/rtl/srim_in_if.sv
hw/rtl/srim_out_if.sv
hw/rtl/srim_ctrl.sv
hw/rtl/srim_dpath.sv
hw/rtl/stage_range_interval_merge.sv
tb/testbench.sv
